[src/rmq_pkg.sv]
// Shared constants and types for the rotation matrix to quaternion converter.
// No dependencies; used by every module of the block.
package rmq_pkg;

    // Default word width of matrix entries and quaternion components (Q2.(W-2)).
    localparam int DATA_WIDTH = 16;

    // Which component carries the half root.
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_W = 2'd0;
    localparam t_sel SEL_X = 2'd1;
    localparam t_sel SEL_Y = 2'd2;
    localparam t_sel SEL_Z = 2'd3;

endpackage

[src/rotation_matrix_to_quaternion_top.sv]
// Throughput: one item per cycle; busy is always low and results are never held.
// Depth is set by the pipelined square root and the three restoring dividers.
// Reset (synchronous, active low) clears every valid bit; no result follows it.
// Top level; depends on rmq_pkg, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion_top #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_m00,
    input  logic signed [DATA_WIDTH-1:0] i_m01,
    input  logic signed [DATA_WIDTH-1:0] i_m02,
    input  logic signed [DATA_WIDTH-1:0] i_m10,
    input  logic signed [DATA_WIDTH-1:0] i_m11,
    input  logic signed [DATA_WIDTH-1:0] i_m12,
    input  logic signed [DATA_WIDTH-1:0] i_m20,
    input  logic signed [DATA_WIDTH-1:0] i_m21,
    input  logic signed [DATA_WIDTH-1:0] i_m22,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_qw,
    output logic signed [DATA_WIDTH-1:0] o_qx,
    output logic signed [DATA_WIDTH-1:0] o_qy,
    output logic signed [DATA_WIDTH-1:0] o_qz,
    output logic                         o_invalid
);
    localparam int W  = DATA_WIDTH;
    localparam int Q  = W - 2;
    localparam int SW = W + 2;

    typedef logic signed [W-1:0] t_word;
    typedef logic signed [SW-1:0] t_wide;

    typedef struct packed {
        logic signed [W:0] a;
        logic signed [W:0] b;
        logic signed [W:0] c;
        rmq_pkg::t_sel     sel;
        logic              bad;
    } t_side;

    typedef struct packed {
        logic [W-2:0]  h;
        rmq_pkg::t_sel sel;
        logic          bad;
    } t_tail;

    assign busy = 1'b0;

    // Stage 1: capture the matrix.
    logic  r_v1;
    t_word r_m [0:8];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_m[0] <= i_m00; r_m[1] <= i_m01; r_m[2] <= i_m02;
        r_m[3] <= i_m10; r_m[4] <= i_m11; r_m[5] <= i_m12;
        r_m[6] <= i_m20; r_m[7] <= i_m21; r_m[8] <= i_m22;
    end

    // Stage 2: trace sign and the largest diagonal entry (lower index wins ties).
    logic          r_v2;
    logic          r_pos;
    rmq_pkg::t_sel r_sel2;
    t_word         r_m2 [0:8];
    t_wide         trace;
    logic          pick1;
    logic          pick2;
    t_word         dmax;
    rmq_pkg::t_sel n_sel2;

    always_comb begin
        trace = t_wide'(r_m[0]) + t_wide'(r_m[4]) + t_wide'(r_m[8]);
        pick1 = r_m[4] > r_m[0];
        dmax  = pick1 ? r_m[4] : r_m[0];
        pick2 = r_m[8] > dmax;
        if (trace > 0) begin
            n_sel2 = rmq_pkg::SEL_W;
        end else if (pick2) begin
            n_sel2 = rmq_pkg::SEL_Z;
        end else if (pick1) begin
            n_sel2 = rmq_pkg::SEL_Y;
        end else begin
            n_sel2 = rmq_pkg::SEL_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_pos  <= trace > 0;
        r_sel2 <= n_sel2;
        for (int k = 0; k < 9; k++) begin
            r_m2[k] <= r_m[k];
        end
    end

    // Stage 3: radicand and the three numerators for the chosen case.
    localparam t_wide ONE = t_wide'(1) <<< Q;
    t_wide             rad;
    logic signed [W:0] na, nb, nc;
    t_wide             e00, e11, e22;

    always_comb begin
        e00 = t_wide'(r_m2[0]);
        e11 = t_wide'(r_m2[4]);
        e22 = t_wide'(r_m2[8]);
        case (r_sel2)
            rmq_pkg::SEL_W: begin
                rad = e00 + e11 + e22 + ONE;
                na  = (W+1)'(r_m2[7]) - (W+1)'(r_m2[5]);
                nb  = (W+1)'(r_m2[2]) - (W+1)'(r_m2[6]);
                nc  = (W+1)'(r_m2[3]) - (W+1)'(r_m2[1]);
            end
            rmq_pkg::SEL_X: begin
                rad = e00 - e11 - e22 + ONE;
                na  = (W+1)'(r_m2[7]) - (W+1)'(r_m2[5]);
                nb  = (W+1)'(r_m2[3]) + (W+1)'(r_m2[1]);
                nc  = (W+1)'(r_m2[6]) + (W+1)'(r_m2[2]);
            end
            rmq_pkg::SEL_Y: begin
                rad = e11 - e22 - e00 + ONE;
                na  = (W+1)'(r_m2[2]) - (W+1)'(r_m2[6]);
                nb  = (W+1)'(r_m2[7]) + (W+1)'(r_m2[5]);
                nc  = (W+1)'(r_m2[1]) + (W+1)'(r_m2[3]);
            end
            default: begin
                rad = e22 - e00 - e11 + ONE;
                na  = (W+1)'(r_m2[3]) - (W+1)'(r_m2[1]);
                nb  = (W+1)'(r_m2[2]) + (W+1)'(r_m2[6]);
                nc  = (W+1)'(r_m2[5]) + (W+1)'(r_m2[7]);
            end
        endcase
    end

    logic           r_v3;
    logic [2*W-3:0] r_rad3;
    t_side          r_side3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_rad3      <= {1'b0, rad[W:0], {(Q-2){1'b0}}};
        r_side3.a   <= na;
        r_side3.b   <= nb;
        r_side3.c   <= nc;
        r_side3.sel <= r_sel2;
        r_side3.bad <= !r_pos && (rad <= 0);
    end

    // Half root.
    logic         sq_v;
    logic [W-2:0] sq_h;
    rmq_sqrt #(.W(W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   (r_rad3),
        .o_valid (sq_v),
        .o_root  (sq_h)
    );

    // Numerators wait alongside the root.
    t_side r_d1 [0:W];
    always_ff @(posedge i_clk) begin
        r_d1[0] <= r_side3;
        for (int k = 1; k <= W; k++) begin
            r_d1[k] <= r_d1[k-1];
        end
    end

    // Three quotients.
    logic  dv_v [0:2];
    t_word dq   [0:2];
    logic signed [W:0] dnum [0:2];
    assign dnum[0] = r_d1[W].a;
    assign dnum[1] = r_d1[W].b;
    assign dnum[2] = r_d1[W].c;

    for (genvar d = 0; d < 3; d++) begin : g_div
        rmq_div #(.W(W)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v),
            .i_num   (dnum[d]),
            .i_root  (sq_h),
            .o_valid (dv_v[d]),
            .o_q     (dq[d])
        );
    end

    // Root and case wait alongside the dividers.
    t_tail r_d2 [0:W+2];
    always_ff @(posedge i_clk) begin
        r_d2[0].h   <= sq_h;
        r_d2[0].sel <= r_d1[W].sel;
        r_d2[0].bad <= r_d1[W].bad;
        for (int k = 1; k <= W + 2; k++) begin
            r_d2[k] <= r_d2[k-1];
        end
    end

    // Output stage: place the root and quotients, zero everything when invalid.
    t_word hw;
    t_word n_qw, n_qx, n_qy, n_qz;
    always_comb begin
        hw = t_word'({1'b0, r_d2[W+2].h});
        case (r_d2[W+2].sel)
            rmq_pkg::SEL_W: begin
                n_qw = hw;    n_qx = dq[0]; n_qy = dq[1]; n_qz = dq[2];
            end
            rmq_pkg::SEL_X: begin
                n_qw = dq[0]; n_qx = hw;    n_qy = dq[1]; n_qz = dq[2];
            end
            rmq_pkg::SEL_Y: begin
                n_qw = dq[0]; n_qy = hw;    n_qz = dq[1]; n_qx = dq[2];
            end
            default: begin
                n_qw = dq[0]; n_qz = hw;    n_qx = dq[1]; n_qy = dq[2];
            end
        endcase
        if (r_d2[W+2].bad) begin
            n_qw = '0; n_qx = '0; n_qy = '0; n_qz = '0;
        end
    end

    logic  r_done;
    t_word r_qw, r_qx, r_qy, r_qz;
    logic  r_inv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_v[0] & dv_v[1] & dv_v[2];
        end
        r_qw  <= n_qw;
        r_qx  <= n_qx;
        r_qy  <= n_qy;
        r_qz  <= n_qz;
        r_inv <= r_d2[W+2].bad;
    end

    assign o_done    = r_done;
    assign o_qw      = r_qw;
    assign o_qx      = r_qx;
    assign o_qy      = r_qy;
    assign o_qz      = r_qz;
    assign o_invalid = r_inv;

endmodule

[src/rmq_sqrt.sv]
// Pipelined integer square root, rounded to nearest, one root bit per stage.
// Depends on rmq_pkg for the default width.
module rmq_sqrt #(
    parameter int W = rmq_pkg::DATA_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2*W-3:0]   i_rad,
    output logic             o_valid,
    output logic [W-2:0]     o_root
);
    localparam int NW = 2 * W - 2;
    localparam int NS = W - 1;

    logic          r_v    [0:NS];
    logic [NW-1:0] r_n    [0:NS];
    logic [W-2:0]  r_r    [0:NS];
    logic [W:0]    r_rem  [0:NS];

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_n[0]   <= i_rad;
        r_r[0]   <= '0;
        r_rem[0] <= '0;
    end

    // One restoring step per stage: bring down two bits, try root*4+1.
    for (genvar s = 0; s < NS; s++) begin : g_step
        logic [W+2:0] remsh;
        logic [W+2:0] trial;
        logic         take;
        logic [W:0]   n_rem;
        logic [W-2:0] n_r;

        always_comb begin
            remsh = {r_rem[s], r_n[s][NW-1:NW-2]};
            trial = {2'b00, r_r[s], 2'b01};
            take  = remsh >= trial;
            n_rem = take ? (W+1)'(remsh - trial) : remsh[W:0];
            n_r   = {r_r[s][W-3:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_n[s+1]   <= {r_n[s][NW-3:0], 2'b00};
            r_r[s+1]   <= n_r;
            r_rem[s+1] <= n_rem;
        end
    end

    // Round to nearest: remainder above the root means the next integer is closer.
    logic            r_ov;
    logic [W-2:0]    r_oroot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[NS];
        end
        r_oroot <= r_r[NS] + (W-1)'(r_rem[NS] > {2'b00, r_r[NS]});
    end

    assign o_valid = r_ov;
    assign o_root  = r_oroot;

endmodule

[src/rmq_div.sv]
// Pipelined signed quotient round(num * 2^(W-2) / (4*root)) with saturation.
// Restoring division, one quotient bit per stage; depends on rmq_pkg.
module rmq_div #(
    parameter int W = rmq_pkg::DATA_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W:0]   i_num,
    input  logic [W-2:0]        i_root,
    output logic                o_valid,
    output logic signed [W-1:0] o_q
);
    localparam int Q = W - 2;

    // Stage A: magnitude, rounded dividend and divisor.
    logic           r_av;
    logic           r_aneg;
    logic [2*W-1:0] r_ad;
    logic [W:0]     r_aden;
    logic [W:0]     mag;

    always_comb begin
        mag = i_num[W] ? (W+1)'(-i_num) : i_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else begin
            r_av <= i_valid;
        end
        r_aneg <= i_num[W];
        r_ad   <= {1'b0, mag, {Q{1'b0}}} + {{W{1'b0}}, i_root, 1'b0};
        r_aden <= {i_root, 2'b00};
    end

    // Step registers; index 0 holds the overflow check and the upper dividend half.
    logic         r_v   [0:W];
    logic         r_neg [0:W];
    logic         r_ovf [0:W];
    logic [W:0]   r_den [0:W];
    logic [W:0]   r_rem [0:W];
    logic [W-1:0] r_lo  [0:W];
    logic [W-1:0] r_q   [0:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_av;
        end
        r_neg[0] <= r_aneg;
        r_ovf[0] <= {1'b0, r_ad[2*W-1:W]} >= r_aden;
        r_den[0] <= r_aden;
        r_rem[0] <= {1'b0, r_ad[2*W-1:W]};
        r_lo[0]  <= r_ad[W-1:0];
        r_q[0]   <= '0;
    end

    // One quotient bit per stage.
    for (genvar s = 0; s < W; s++) begin : g_step
        logic [W+1:0] remsh;
        logic         take;
        logic [W:0]   n_rem;

        always_comb begin
            remsh = {r_rem[s], r_lo[s][W-1]};
            take  = remsh >= {1'b0, r_den[s]};
            n_rem = take ? (W+1)'(remsh - {1'b0, r_den[s]}) : remsh[W:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
            r_den[s+1] <= r_den[s];
            r_rem[s+1] <= n_rem;
            r_lo[s+1]  <= {r_lo[s][W-2:0], 1'b0};
            r_q[s+1]   <= {r_q[s][W-2:0], take};
        end
    end

    // Apply sign and saturate to the signed word range.
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

    logic              r_ov;
    logic signed [W-1:0] r_oq;
    logic signed [W-1:0] n_oq;

    always_comb begin
        if (r_neg[W]) begin
            if (r_ovf[W] || r_q[W] > MIN_MAG) begin
                n_oq = MIN_MAG;
            end else begin
                n_oq = -r_q[W];
            end
        end else begin
            if (r_ovf[W] || r_q[W] > MAX_POS) begin
                n_oq = MAX_POS;
            end else begin
                n_oq = r_q[W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[W];
        end
        r_oq <= n_oq;
    end

    assign o_valid = r_ov;
    assign o_q     = r_oq;

endmodule
